@@ rtl/rftl_pkg.sv @@
// Shared types, constants and the FIR coefficient table of the RF tracking loop.
// No dependencies.
`timescale 1ns / 1ps

package rftl_pkg;

	localparam int TAPS      = 11;
	localparam int TAP_W     = 4;
	localparam int DIV_BITS  = 29;   // |tau| * 15625 < 2^29
	localparam int PSUM_W    = 26;
	localparam int ISUM_W    = 21;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 32;

	localparam logic [13:0] PPM_SCALE  = 14'd15625;
	localparam logic [11:0] IF_HIST_RST = 12'd500;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_ARRIVAL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_INIT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_UPDATE_RATE      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CHIP_ERROR_LIMIT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PPM_LIMIT        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_IF_LOW           = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_IF_HIGH          = 3'd6;

	// Step command codes
	localparam logic [1:0] STEP_NONE = 2'd0;
	localparam logic [1:0] STEP_UP   = 2'd1;
	localparam logic [1:0] STEP_DOWN = 2'd2;

	typedef struct packed {
		logic [6:0]         packet_length;
		logic signed [15:0] clock_tau;
		logic [11:0]        if_zero_crossings;
		logic [7:0]         chip_errors;
		logic [31:0]        arrival_stamp;
		logic [4:0]         rf_channel;
	} in_t;

	typedef struct packed {
		logic [31:0]        timer_max_count;
		logic [31:0]        interval_now;
		logic signed [15:0] ppm_filtered;
		logic [11:0]        if_filtered;
		logic [1:0]         if_fine_step;
		logic [1:0]         channel_step;
		logic [3:0]         channel_index;
	} out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_PUSH,
		ST_FIR,
		ST_DONE
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic             accept;
		logic             mul;
		logic             div_step;
		logic             push;
		logic             mac;
		logic [TAP_W-1:0] tap;
		logic             finish;
	} cmd_t;

	// Symmetric FIR weights, sum 512
	function automatic logic [6:0] fir_coef(input logic [TAP_W-1:0] k);
		logic [6:0] c;
		case (k)
			4'd0, 4'd10: c = 7'd4;
			4'd1, 4'd9:  c = 7'd16;
			4'd2, 4'd8:  c = 7'd37;
			4'd3, 4'd7:  c = 7'd64;
			4'd4, 4'd6:  c = 7'd87;
			4'd5:        c = 7'd96;
			default:     c = 7'd0;
		endcase
		return c;
	endfunction

endpackage

@@ rtl/rftl_ctrl.sv @@
// Sequencer of the RF tracking loop: divide, history push, FIR sweep, result handoff.
// Depends on rftl_pkg.
`timescale 1ns / 1ps

module rftl_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output rftl_pkg::cmd_t cmd
);
	import rftl_pkg::*;

	state_t     state_q, state_d;
	logic [4:0] cnt_q, cnt_d;
	logic       out_valid_q;

	// State and counter registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		cmd          = '0;
		cmd.tap      = cnt_q[TAP_W-1:0];
		in_ready     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				cnt_d   = '0;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 5'd1;
				if (cnt_q == 5'(DIV_BITS - 1)) begin
					state_d = ST_PUSH;
				end
			end
			ST_PUSH: begin
				cmd.push = 1'b1;
				cnt_d    = '0;
				state_d  = ST_FIR;
			end
			ST_FIR: begin
				cmd.mac = 1'b1;
				cnt_d   = cnt_q + 5'd1;
				if (cnt_q == 5'(TAPS - 1)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				// wait for the output register to free up
				if (!out_valid_q || out_ready) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ rtl/rftl_datapath.sv @@
// Datapath of the RF tracking loop: config registers, interval, divider, FIR MACs,
// histories and output register. Depends on rftl_pkg.
`timescale 1ns / 1ps

module rftl_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rftl_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rftl_pkg::CFG_W-1:0]        cfg_data,
	input  rftl_pkg::in_t                     in_data,
	input  rftl_pkg::cmd_t                    cmd,
	output rftl_pkg::out_t                    out_data
);
	import rftl_pkg::*;

	// Configuration
	logic [31:0] exp_arr_q;
	logic [15:0] upd_rate_q;
	logic [7:0]  chip_lim_q;
	logic [14:0] ppm_lim_q;
	logic [11:0] if_low_q, if_high_q;

	// Loop state
	logic [31:0] interval_q;
	logic [15:0] cooldown_q;
	logic [15:0] ppm_hist_q [TAPS];
	logic [11:0] if_hist_q [TAPS];
	logic [11:0] if_last_q;

	// Per-packet work registers
	logic [6:0]          len_q;
	logic                tau_neg_q;
	logic [15:0]         tau_abs_q;
	logic [11:0]         ifz_q;
	logic                chips_ok_q;
	logic [3:0]          chan_idx_q;
	logic                at_end_q;
	logic [31:0]         corr_q, max_q;
	logic [DIV_BITS-1:0] quo_q;
	logic [9:0]          rem_q;
	logic signed [PSUM_W-1:0] psum_q;
	logic [ISUM_W-1:0]   isum_q;
	out_t                out_q;

	logic [31:0] corr, interval_upd;
	logic [15:0] cooldown_inc, tau_abs;
	logic [29:0] prod;
	logic [10:0] rem_sh;
	logic [9:0]  divisor;
	logic        rem_ge;
	logic [15:0] ppm_mag, ppm16;
	logic signed [22:0] pprod;
	logic [18:0] iprod;
	logic signed [PSUM_W-1:0] psum_rnd;
	logic signed [16:0] pfilt, plim;
	logic [11:0] ifilt;
	logic        if_up, if_dn;
	logic [1:0]  fine, chstep;

	assign corr         = exp_arr_q - in_data.arrival_stamp;
	assign interval_upd = interval_q - corr;
	assign cooldown_inc = cooldown_q + 16'd1;
	assign tau_abs      = in_data.clock_tau[15] ? 16'(-in_data.clock_tau) : in_data.clock_tau;

	// |tau| * 15625
	assign prod = tau_abs_q * PPM_SCALE;

	// Restoring divide step by len * 8
	assign divisor = {len_q, 3'b000};
	assign rem_sh  = {rem_q, quo_q[DIV_BITS-1]};
	assign rem_ge  = rem_sh >= {1'b0, divisor};

	// Signed ppm, kept in 16 bits; zero length gives zero
	assign ppm_mag = quo_q[15:0];
	always_comb begin
		if (len_q == 7'd0) begin
			ppm16 = '0;
		end else if (tau_neg_q) begin
			ppm16 = -ppm_mag;
		end else begin
			ppm16 = ppm_mag;
		end
	end

	// Tap products
	assign pprod = $signed(ppm_hist_q[cmd.tap]) * $signed({1'b0, fir_coef(cmd.tap)});
	assign iprod = if_hist_q[cmd.tap] * fir_coef(cmd.tap);

	// Divide by 512 toward zero
	assign psum_rnd = psum_q + (psum_q[PSUM_W-1] ? PSUM_W'(511) : PSUM_W'(0));
	assign pfilt    = 17'(psum_rnd >>> 9);
	assign plim     = {2'b00, ppm_lim_q};
	assign ifilt    = isum_q[ISUM_W-1:9];

	// Step decisions
	always_comb begin
		fine = STEP_NONE;
		if (at_end_q) begin
			if (pfilt > plim) begin
				fine = STEP_UP;
			end
			if (pfilt < -plim) begin
				fine = STEP_DOWN;
			end
		end
		if_up  = ifilt > if_high_q;
		if_dn  = ifilt < if_low_q;
		chstep = STEP_NONE;
		if (chips_ok_q && at_end_q) begin
			if (if_up && !if_dn) begin
				chstep = STEP_UP;
			end else if (if_dn && !if_up) begin
				chstep = STEP_DOWN;
			end
		end
	end

	// Configuration, interval and cooldown
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_arr_q  <= '0;
			upd_rate_q <= 16'd15;
			chip_lim_q <= 8'd25;
			ppm_lim_q  <= 15'd1000;
			if_low_q   <= 12'd480;
			if_high_q  <= 12'd520;
			interval_q <= '0;
			cooldown_q <= '0;
			if_last_q  <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_EXPECTED_ARRIVAL: exp_arr_q  <= cfg_data;
					REG_INTERVAL_INIT:    interval_q <= cfg_data;
					REG_UPDATE_RATE:      upd_rate_q <= cfg_data[15:0];
					REG_CHIP_ERROR_LIMIT: chip_lim_q <= cfg_data[7:0];
					REG_PPM_LIMIT:        ppm_lim_q  <= cfg_data[14:0];
					REG_IF_LOW:           if_low_q   <= cfg_data[11:0];
					REG_IF_HIGH:          if_high_q  <= cfg_data[11:0];
					default: ;
				endcase
			end
			if (cmd.accept) begin
				interval_q <= interval_upd;
				cooldown_q <= cooldown_inc;
			end
			if (cmd.finish && chips_ok_q) begin
				if_last_q <= ifilt;
				if (at_end_q) begin
					cooldown_q <= '0;
				end
			end
		end
	end

	// Filter histories
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TAPS; k++) begin
				ppm_hist_q[k] <= '0;
				if_hist_q[k]  <= (k < TAPS - 1) ? IF_HIST_RST : 12'd0;
			end
		end else if (cmd.push) begin
			ppm_hist_q[0] <= ppm16;
			for (int k = 1; k < TAPS; k++) begin
				ppm_hist_q[k] <= ppm_hist_q[k-1];
			end
			if (chips_ok_q) begin
				if_hist_q[0] <= ifz_q;
				for (int k = 1; k < TAPS; k++) begin
					if_hist_q[k] <= if_hist_q[k-1];
				end
			end
		end
	end

	// Per-packet work registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			len_q      <= in_data.packet_length;
			tau_neg_q  <= in_data.clock_tau[15];
			tau_abs_q  <= tau_abs;
			ifz_q      <= in_data.if_zero_crossings;
			chips_ok_q <= in_data.chip_errors < chip_lim_q;
			chan_idx_q <= 4'(in_data.rf_channel - 5'd11);
			at_end_q   <= cooldown_inc == upd_rate_q;
			corr_q     <= corr;
		end
		if (cmd.mul) begin
			max_q <= interval_q - corr_q;
			quo_q <= prod[DIV_BITS-1:0];
			rem_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= rem_ge ? 10'(rem_sh - {1'b0, divisor}) : rem_sh[9:0];
			quo_q <= {quo_q[DIV_BITS-2:0], rem_ge};
		end
		if (cmd.push) begin
			psum_q <= '0;
			isum_q <= '0;
		end
		if (cmd.mac) begin
			psum_q <= psum_q + PSUM_W'(pprod);
			isum_q <= isum_q + ISUM_W'(iprod);
		end
		if (cmd.finish) begin
			out_q.timer_max_count <= max_q;
			out_q.interval_now    <= interval_q;
			out_q.ppm_filtered    <= pfilt[15:0];
			out_q.if_filtered     <= chips_ok_q ? ifilt : if_last_q;
			out_q.if_fine_step    <= fine;
			out_q.channel_step    <= chstep;
			out_q.channel_index   <= chan_idx_q;
		end
	end

	assign out_data = out_q;

endmodule

@@ rtl/radio_frequency_tracking_loop.sv @@
// Top level of the RF tracking loop: sequencer plus datapath.
// Depends on rftl_pkg, rftl_ctrl, rftl_datapath.
//
//  channel | signals                        | moves
//  --------+--------------------------------+-------------------------------
//  in      | in_valid, in_ready, in_data    | one packet report per transfer
//  out     | out_valid, out_ready, out_data | one loop result per transfer
//  cfg     | cfg_we, cfg_index, cfg_data    | one register write per cycle
//
// An item goes from transfer to result through one multiply, 29 restoring divide
// steps for the ppm conversion, one history push, 11 FIR taps and one handoff.
// The sequencer then idles; it takes no new input while an item is in work.
// in_ready is high only while the sequencer is idle; a finished result waits in the
// output register and does not block the next input transfer, only the next handoff.
// Reset restores the register defaults and the filter histories at once.
`timescale 1ns / 1ps

module radio_frequency_tracking_loop (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  rftl_pkg::in_t                  in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output rftl_pkg::out_t                 out_data,
	input  logic                           cfg_we,
	input  logic [rftl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rftl_pkg::CFG_W-1:0]     cfg_data
);
	import rftl_pkg::*;

	cmd_t cmd;

	rftl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	rftl_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.out_data  (out_data)
	);

endmodule

@@ rtl/rftl_checker.sv @@
// Port-level checks of the RF tracking loop, bound to the top level.
// Depends on rftl_pkg and radio_frequency_tracking_loop.
`timescale 1ns / 1ps

module rftl_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input rftl_pkg::in_t                  in_data,
	input logic                           out_valid,
	input logic                           out_ready,
	input rftl_pkg::out_t                 out_data,
	input logic                           cfg_we,
	input logic [rftl_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [rftl_pkg::CFG_W-1:0]     cfg_data
);
	import rftl_pkg::*;

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// One item in work at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while busy");

	// A new result appears only as the sequencer returns to idle
	a_rose_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result without return to idle");

	// Step codes stay within their defined set
	a_codes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.if_fine_step != 2'd3 && out_data.channel_step != 2'd3)
		else $error("undefined step code");

endmodule

bind radio_frequency_tracking_loop rftl_checker u_rftl_checker (.*);

@@ bench/radio_frequency_tracking_loop_tb.sv @@
// Self-checking bench for the RF tracking loop: directed packets, register sweeps
// and random traffic under random stalls. Depends on rftl_pkg and the RTL top.
`timescale 1ns / 1ps

module radio_frequency_tracking_loop_tb;
	import rftl_pkg::*;

	localparam int FIR_W [TAPS] = '{4, 16, 37, 64, 87, 96, 87, 64, 37, 16, 4};

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	in_t                  in_data;
	logic                 out_valid;
	logic                 out_ready;
	out_t                 out_data;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	radio_frequency_tracking_loop DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Loop registers and state as the bench tracks them
	logic [31:0] arrival_exp, interval_st;
	logic [15:0] rate_reg, cooldown_st;
	logic [7:0]  chip_lim;
	logic [14:0] ppm_lim;
	logic [11:0] if_lo, if_hi, if_last;
	logic [15:0] ppm_hist [TAPS];
	logic [11:0] if_hist [TAPS];

	out_t loop_results [$];
	int   errors, n_pkts, n_fine, n_chan, n_results;
	bit   gaps_on;
	int   burst_left;
	int   rx_mode;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Tracking loop behavior for one packet; updates state
	function automatic out_t track_packet(input in_t p);
		out_t r;
		logic [31:0] corr;
		int ppm, psum, pfilt, isum, net;
		bit at_end;
		corr = arrival_exp - p.arrival_stamp;
		interval_st = interval_st - corr;
		r.timer_max_count = interval_st - corr;
		r.interval_now = interval_st;
		cooldown_st = cooldown_st + 16'd1;
		at_end = (cooldown_st == rate_reg);
		if (p.packet_length == 0)
			ppm = 0;
		else
			ppm = (int'(p.clock_tau) * 15625) / (int'(p.packet_length) * 8);
		for (int k = TAPS - 1; k > 0; k--)
			ppm_hist[k] = ppm_hist[k-1];
		ppm_hist[0] = ppm[15:0];
		psum = 0;
		for (int k = 0; k < TAPS; k++)
			psum += int'($signed(ppm_hist[k])) * FIR_W[k];
		pfilt = psum / 512;
		r.ppm_filtered = pfilt[15:0];
		r.if_fine_step = STEP_NONE;
		if (at_end && pfilt > int'(ppm_lim))
			r.if_fine_step = STEP_UP;
		if (at_end && pfilt < -int'(ppm_lim))
			r.if_fine_step = STEP_DOWN;
		r.channel_step = STEP_NONE;
		if (p.chip_errors < chip_lim) begin
			for (int k = TAPS - 1; k > 0; k--)
				if_hist[k] = if_hist[k-1];
			if_hist[0] = p.if_zero_crossings;
			isum = 0;
			for (int k = 0; k < TAPS; k++)
				isum += int'(if_hist[k]) * FIR_W[k];
			isum = isum / 512;
			if_last = isum[11:0];
			if (at_end) begin
				net = 0;
				if (if_last > if_hi)
					net++;
				if (if_last < if_lo)
					net--;
				r.channel_step = (net > 0) ? STEP_UP : (net < 0) ? STEP_DOWN : STEP_NONE;
				cooldown_st = '0;
			end
		end
		r.if_filtered = if_last;
		r.channel_index = p.rf_channel[3:0] - 4'd11;
		return r;
	endfunction

	// Register write, issued only while the loop is idle
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_EXPECTED_ARRIVAL: arrival_exp = val;
			REG_INTERVAL_INIT:    interval_st = val;
			REG_UPDATE_RATE:      rate_reg = val[15:0];
			REG_CHIP_ERROR_LIMIT: chip_lim = val[7:0];
			REG_PPM_LIMIT:        ppm_lim = val[14:0];
			REG_IF_LOW:           if_lo = val[11:0];
			REG_IF_HIGH:          if_hi = val[11:0];
			default: ;
		endcase
	endtask

	// One packet transfer; entered and left at a falling edge
	task automatic send_pkt(input in_t p);
		if (gaps_on && burst_left == 0) begin
			repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = $urandom_range(1, 16);
		end
		in_data = p;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		loop_results.push_back(track_packet(p));
		if (loop_results[$].if_fine_step != STEP_NONE)
			n_fine++;
		if (loop_results[$].channel_step != STEP_NONE)
			n_chan++;
		n_pkts++;
		if (burst_left > 0)
			burst_left--;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// Wait for every pending result, then for the pipeline to settle
	task automatic drain();
		while (loop_results.size() != 0)
			@(negedge clk);
		repeat (50) @(negedge clk);
	endtask

	function automatic in_t mk_pkt(input int len, input int tau, input int ifz,
			input int chips, input logic [31:0] stamp, input int chan);
		in_t p;
		p.packet_length = len[6:0];
		p.clock_tau = tau[15:0];
		p.if_zero_crossings = ifz[11:0];
		p.chip_errors = chips[7:0];
		p.arrival_stamp = stamp;
		p.rf_channel = chan[4:0];
		return p;
	endfunction

	// Mostly realistic packets: IF near the thresholds, stamp near expectation
	function automatic in_t rand_pkt();
		in_t p;
		p.packet_length = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 3)) : 7'($urandom);
		p.clock_tau = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
			16'($signed($urandom_range(0, 400)) - 200);
		p.if_zero_crossings = ($urandom_range(0, 4) == 0) ? 12'($urandom) :
			12'($urandom_range(440, 560));
		p.chip_errors = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 30));
		p.arrival_stamp = ($urandom_range(0, 3) == 0) ? 32'($urandom) :
			arrival_exp + 32'($urandom_range(0, 64)) - 32'd32;
		p.rf_channel = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(11, 26));
		return p;
	endfunction

	// Result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			n_results++;
			if (loop_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result %h", $time, out_data);
			end else begin
				out_t e;
				e = loop_results.pop_front();
				if (out_data.timer_max_count !== e.timer_max_count) begin
					errors++;
					$display("%0t: timer_max_count exp %h got %h", $time,
						e.timer_max_count, out_data.timer_max_count);
				end
				if (out_data.interval_now !== e.interval_now) begin
					errors++;
					$display("%0t: interval_now exp %h got %h", $time,
						e.interval_now, out_data.interval_now);
				end
				if (out_data.ppm_filtered !== e.ppm_filtered) begin
					errors++;
					$display("%0t: ppm_filtered exp %0d got %0d", $time,
						e.ppm_filtered, out_data.ppm_filtered);
				end
				if (out_data.if_filtered !== e.if_filtered) begin
					errors++;
					$display("%0t: if_filtered exp %0d got %0d", $time,
						e.if_filtered, out_data.if_filtered);
				end
				if (out_data.if_fine_step !== e.if_fine_step) begin
					errors++;
					$display("%0t: if_fine_step exp %0d got %0d", $time,
						e.if_fine_step, out_data.if_fine_step);
				end
				if (out_data.channel_step !== e.channel_step) begin
					errors++;
					$display("%0t: channel_step exp %0d got %0d", $time,
						e.channel_step, out_data.channel_step);
				end
				if (out_data.channel_index !== e.channel_index) begin
					errors++;
					$display("%0t: channel_index exp %0d got %0d", $time,
						e.channel_index, out_data.channel_index);
				end
			end
		end
	end

	// Receiver stall patterns
	always @(negedge clk) begin
		case (rx_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 3) != 0);
			2: out_ready <= ($urandom_range(0, 15) == 0);
			default: out_ready <= $urandom_range(0, 1);
		endcase
	end

	// Reset defaults first, then the corners of every field
	task automatic test_directed();
		gaps_on = 0;
		rx_mode = 0;
		send_pkt(mk_pkt(0, 32767, 500, 0, 32'd0, 11));
		send_pkt(mk_pkt(1, -32768, 0, 0, 32'hFFFF_FFFF, 26));
		send_pkt(mk_pkt(1, 32767, 4095, 0, 32'h8000_0000, 0));
		send_pkt(mk_pkt(127, -1, 4095, 255, 32'd1, 31));
		send_pkt(mk_pkt(127, 32767, 0, 24, 32'h7FFF_FFFF, 15));
		send_pkt(mk_pkt(2, -20000, 100, 25, 32'd5, 12));
		for (int i = 0; i < 9; i++)
			send_pkt(mk_pkt(1, 30000, 4000, 0, 32'd0, 20));
		send_pkt(mk_pkt(1, -30000, 10, 0, 32'd3, 13));
		drain();
		// cooldown end with high chip errors: no clear, no channel step
		cfg_write(REG_UPDATE_RATE, 32'd2);
		send_pkt(mk_pkt(1, -30000, 10, 200, 32'd0, 14));
		send_pkt(mk_pkt(1, -30000, 10, 0, 32'd0, 14));
		drain();
		// crossed thresholds cancel at a cooldown end
		cfg_write(REG_UPDATE_RATE, 32'd4);
		cfg_write(REG_IF_LOW, 32'd4095);
		cfg_write(REG_IF_HIGH, 32'd0);
		send_pkt(mk_pkt(64, 123, 700, 0, 32'd9, 16));
		drain();
	endtask

	task automatic run_random(input int count);
		repeat (count) send_pkt(rand_pkt());
	endtask

	// Register settings including extremes, random traffic in each
	task automatic test_config_sweep();
		gaps_on = 1;
		for (int ph = 0; ph < 6; ph++) begin
			drain();
			rx_mode = ph % 4;
			cfg_write(REG_EXPECTED_ARRIVAL, (ph == 1) ? 32'hFFFF_FFFF : $urandom);
			cfg_write(REG_INTERVAL_INIT, (ph == 2) ? 32'hFFFF_FFFF : $urandom);
			case (ph)
				0: cfg_write(REG_UPDATE_RATE, 32'd0);
				1: cfg_write(REG_UPDATE_RATE, 32'hFFFF);
				default: cfg_write(REG_UPDATE_RATE, $urandom_range(1, 4));
			endcase
			cfg_write(REG_CHIP_ERROR_LIMIT, (ph == 3) ? 32'd0 : (ph == 4) ? 32'd255 : 32'd25);
			cfg_write(REG_PPM_LIMIT, (ph == 3) ? 32'd0 : (ph == 4) ? 32'h7FFF :
				$urandom_range(0, 3000));
			cfg_write(REG_IF_LOW, (ph == 5) ? 32'd0 : $urandom_range(470, 500));
			cfg_write(REG_IF_HIGH, (ph == 5) ? 32'd4095 : $urandom_range(500, 530));
			run_random(80);
		end
		drain();
	endtask

	// Default-like thresholds, fast cooldown, stalls of every kind
	task automatic test_random_traffic();
		cfg_write(REG_UPDATE_RATE, 32'd2);
		cfg_write(REG_CHIP_ERROR_LIMIT, 32'd25);
		cfg_write(REG_PPM_LIMIT, 32'd500);
		cfg_write(REG_IF_LOW, 32'd480);
		cfg_write(REG_IF_HIGH, 32'd520);
		for (int blk = 0; blk < 8; blk++) begin
			gaps_on = (blk % 3 != 0);
			rx_mode = blk % 4;
			run_random(25);
		end
	endtask

	// Sender holds off until the loop has emptied, mid-traffic
	task automatic test_hold_off();
		rx_mode = 2;
		run_random(20);
		while (loop_results.size() != 0)
			@(negedge clk);
		rx_mode = 3;
		run_random(20);
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		errors = 0;
		n_pkts = 0;
		n_fine = 0;
		n_chan = 0;
		n_results = 0;
		burst_left = 0;
		gaps_on = 0;
		rx_mode = 0;
		arrival_exp = '0;
		interval_st = '0;
		rate_reg = 16'd15;
		chip_lim = 8'd25;
		ppm_lim = 15'd1000;
		if_lo = 12'd480;
		if_hi = 12'd520;
		if_last = '0;
		cooldown_st = '0;
		for (int k = 0; k < TAPS; k++) begin
			ppm_hist[k] = '0;
			if_hist[k] = (k < TAPS - 1) ? 12'd500 : 12'd0;
		end
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_config_sweep();
		test_random_traffic();
		test_hold_off();
		drain();
		$display("Covered %0d packets, %0d results: %0d IF fine steps, %0d channel steps,",
			n_pkts, n_results, n_fine, n_chan);
		$display("over default, extreme and random register settings with random stalls.");
		if (errors == 0)
			$display("PASS radio_frequency_tracking_loop");
		else
			$display("FAIL radio_frequency_tracking_loop");
		$finish;
	end

	// Watchdog
	initial begin
		#10ms;
		$display("FAIL radio_frequency_tracking_loop");
		$finish;
	end

endmodule
